// ===== hdl/pbrb_pkg.sv =====
package pbrb_pkg;

  // Operation codes as they arrive on the input channel
  typedef enum logic [2:0] {
    OP_WRITE_BEGIN = 3'd0,
    OP_WRITE_BYTE  = 3'd1,
    OP_READ_BYTE   = 3'd2,
    OP_OPEN_END    = 3'd3,
    OP_CLOSE_END   = 3'd4,
    OP_POLL        = 3'd5,
    OP_NONE        = 3'd6
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_WOULD_BLOCK = 3'd1,
    ST_EOF         = 3'd2,
    ST_NO_ROOM     = 3'd3,
    ST_BROKEN_PIPE = 3'd4,
    ST_NO_READER   = 3'd5
  } status_e;

  // End access modes
  localparam logic [1:0] SIDE_READ  = 2'd0;
  localparam logic [1:0] SIDE_WRITE = 2'd1;
  localparam logic [1:0] SIDE_BOTH  = 2'd2;

  localparam int unsigned REQ_W  = 16;
  localparam int unsigned OUT_CW = 13;

  // Input beat
  typedef struct packed {
    logic [2:0]       opcode;
    logic [7:0]       data_in;
    logic [REQ_W-1:0] request_length;
    logic [1:0]       end_side;
    logic             nonblock;
    logic [1:0]       events_wanted;
  } in_t;

  // Output beat
  typedef struct packed {
    status_e           status;
    logic [7:0]        data_out;
    logic [OUT_CW-1:0] grant;
    logic              readable;
    logic              writable;
    logic              hangup;
    logic              poll_error;
    logic [OUT_CW-1:0] bytes_used;
  } out_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [7:0]       data;
    logic [REQ_W-1:0] req;
    logic             req_atomic;  // request short enough to be all-or-nothing
    logic             side_valid;  // side code is not the unused one
    logic             rside;       // end includes reading
    logic             wside;       // end includes writing
    logic             rd_only;
    logic             wr_only;
    logic             poll_rd;     // poll looks at read readiness
    logic             poll_wr;     // poll looks at write readiness
    logic             nonblock;
    logic [1:0]       events;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic {
    B_IDLE,
    B_READ
  } back_state_e;

endpackage

// ===== hdl/pbrb_front.sv =====
module pbrb_front #(
  parameter int unsigned ATOMIC_LIMIT = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pbrb_pkg::in_t    in_i,
  output logic             cmd_valid_o,
  output pbrb_pkg::cmd_t   cmd_o,
  input  logic             cmd_pop_i
);

  pbrb_pkg::cmd_t cmd_new;
  pbrb_pkg::cmd_t slot_q [2];
  logic           wr_idx_q, wr_idx_d;
  logic           rd_idx_q, rd_idx_d;
  logic [1:0]     count_q, count_d;
  logic           push;

  // Decode the incoming beat into a command
  always_comb begin
    cmd_new            = '0;
    case (in_i.opcode)
      pbrb_pkg::OP_WRITE_BEGIN: cmd_new.op = pbrb_pkg::OP_WRITE_BEGIN;
      pbrb_pkg::OP_WRITE_BYTE:  cmd_new.op = pbrb_pkg::OP_WRITE_BYTE;
      pbrb_pkg::OP_READ_BYTE:   cmd_new.op = pbrb_pkg::OP_READ_BYTE;
      pbrb_pkg::OP_OPEN_END:    cmd_new.op = pbrb_pkg::OP_OPEN_END;
      pbrb_pkg::OP_CLOSE_END:   cmd_new.op = pbrb_pkg::OP_CLOSE_END;
      pbrb_pkg::OP_POLL:        cmd_new.op = pbrb_pkg::OP_POLL;
      default:                  cmd_new.op = pbrb_pkg::OP_NONE;
    endcase
    cmd_new.data       = in_i.data_in;
    cmd_new.req        = in_i.request_length;
    cmd_new.req_atomic = ({1'b0, in_i.request_length} <= 17'(ATOMIC_LIMIT));
    cmd_new.rd_only    = (in_i.end_side == pbrb_pkg::SIDE_READ);
    cmd_new.wr_only    = (in_i.end_side == pbrb_pkg::SIDE_WRITE);
    cmd_new.rside      = cmd_new.rd_only || (in_i.end_side == pbrb_pkg::SIDE_BOTH);
    cmd_new.wside      = cmd_new.wr_only || (in_i.end_side == pbrb_pkg::SIDE_BOTH);
    cmd_new.side_valid = cmd_new.rside || cmd_new.wside;
    cmd_new.poll_rd    = !cmd_new.wr_only;
    cmd_new.poll_wr    = !cmd_new.rd_only;
    cmd_new.nonblock   = in_i.nonblock;
    cmd_new.events     = in_i.events_wanted;
  end

  // Two-entry queue between the halves
  assign in_ready_o  = (count_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_idx_q];

  always_comb begin
    wr_idx_d = push ? ~wr_idx_q : wr_idx_q;
    rd_idx_d = cmd_pop_i ? ~rd_idx_q : rd_idx_q;
    count_d  = count_q;
    if (push && !cmd_pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && cmd_pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= 1'b0;
      rd_idx_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  // Queue slots carry payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_idx_q] <= cmd_new;
    end
  end

endmodule

// ===== hdl/pbrb_back.sv =====
module pbrb_back #(
  parameter int unsigned CAPACITY      = 4096,
  parameter int unsigned END_COUNT_MAX = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  pbrb_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pbrb_pkg::out_t   out_o
);

  localparam int unsigned PTR_W  = $clog2(CAPACITY);
  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);
  localparam int unsigned CNT_W  = $clog2(END_COUNT_MAX + 1);
  localparam int unsigned GW     = (FILL_W > pbrb_pkg::REQ_W) ? FILL_W : pbrb_pkg::REQ_W;
  localparam int unsigned UW     = (FILL_W > pbrb_pkg::OUT_CW) ? FILL_W : pbrb_pkg::OUT_CW;

  pbrb_pkg::back_state_e state_q, state_d;

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0]  readers_q, readers_d;
  logic [CNT_W-1:0]  writers_q, writers_d;
  logic              out_valid_q, out_valid_d;
  pbrb_pkg::out_t    out_q, out_d;

  logic [7:0]        ring_q [CAPACITY];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;

  logic              exec;
  logic              slot_free;
  logic [FILL_W-1:0] room_left;
  logic [GW-1:0]     req_ext, free_ext, grant_ext;
  logic [UW-1:0]     used_ext;
  logic              ring_full;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign exec       = (state_q == pbrb_pkg::B_IDLE) && cmd_valid_i && slot_free;
  assign cmd_pop_o  = exec;
  assign room_left  = FILL_W'(CAPACITY) - fill_q;
  assign ring_full  = (fill_q >= FILL_W'(CAPACITY));
  assign req_ext    = GW'(cmd_i.req);
  assign free_ext   = GW'(room_left);

  // Atomic rule for write requests
  always_comb begin
    if (cmd_i.req_atomic && (free_ext < req_ext)) begin
      grant_ext = '0;
    end else begin
      grant_ext = (req_ext < free_ext) ? req_ext : free_ext;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbrb_pkg::B_IDLE: begin
        if (mem_re) begin
          state_d = pbrb_pkg::B_READ;
        end
      end
      pbrb_pkg::B_READ: state_d = pbrb_pkg::B_IDLE;
      default:          state_d = pbrb_pkg::B_IDLE;
    endcase
  end

  // Execute the command and build the result beat
  always_comb begin
    rd_ptr_d    = rd_ptr_q;
    wr_ptr_d    = wr_ptr_q;
    fill_d      = fill_q;
    readers_d   = readers_q;
    writers_d   = writers_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    used_ext    = '0;

    if (state_q == pbrb_pkg::B_READ) begin
      // popped byte arrives in the cycle after the ring read
      out_valid_d    = 1'b1;
      out_d.data_out = rdata_q;
    end else if (exec) begin
      out_d        = '0;
      out_d.status = pbrb_pkg::ST_OK;
      out_valid_d  = 1'b1;
      case (cmd_i.op)
        pbrb_pkg::OP_WRITE_BEGIN: begin
          if (readers_q == '0) begin
            out_d.status = pbrb_pkg::ST_BROKEN_PIPE;
          end else if (cmd_i.req != '0) begin
            out_d.grant = grant_ext[pbrb_pkg::OUT_CW-1:0];
            if (grant_ext == '0) begin
              out_d.status = pbrb_pkg::ST_WOULD_BLOCK;
            end
          end
        end
        pbrb_pkg::OP_WRITE_BYTE: begin
          if (readers_q == '0) begin
            out_d.status = pbrb_pkg::ST_BROKEN_PIPE;
          end else if (ring_full) begin
            out_d.status = pbrb_pkg::ST_NO_ROOM;
          end else begin
            mem_we   = 1'b1;
            wr_ptr_d = (wr_ptr_q == PTR_W'(CAPACITY - 1)) ? '0 : wr_ptr_q + 1'b1;
            fill_d   = fill_q + 1'b1;
          end
        end
        pbrb_pkg::OP_READ_BYTE: begin
          if (fill_q != '0) begin
            mem_re      = 1'b1;
            out_valid_d = 1'b0;
            rd_ptr_d    = (rd_ptr_q == PTR_W'(CAPACITY - 1)) ? '0 : rd_ptr_q + 1'b1;
            fill_d      = fill_q - 1'b1;
          end else if (writers_q == '0) begin
            out_d.status = pbrb_pkg::ST_EOF;
          end else begin
            out_d.status = pbrb_pkg::ST_WOULD_BLOCK;
          end
        end
        pbrb_pkg::OP_OPEN_END: begin
          if (cmd_i.side_valid) begin
            if (cmd_i.wr_only && cmd_i.nonblock && (readers_q == '0)) begin
              out_d.status = pbrb_pkg::ST_NO_READER;
            end else begin
              if (cmd_i.rside && (readers_q < CNT_W'(END_COUNT_MAX))) begin
                readers_d = readers_q + 1'b1;
              end
              if (cmd_i.wside && (writers_q < CNT_W'(END_COUNT_MAX))) begin
                writers_d = writers_q + 1'b1;
              end
              if ((cmd_i.rd_only && !cmd_i.nonblock && (writers_d == '0)) ||
                  (cmd_i.wr_only && (readers_d == '0))) begin
                out_d.status = pbrb_pkg::ST_WOULD_BLOCK;
              end
            end
          end
        end
        pbrb_pkg::OP_CLOSE_END: begin
          if (cmd_i.side_valid) begin
            if (cmd_i.rside && (readers_q != '0)) begin
              readers_d = readers_q - 1'b1;
            end
            if (cmd_i.wside && (writers_q != '0)) begin
              writers_d = writers_q - 1'b1;
            end
            // last end gone: empty the ring
            if ((readers_d == '0) && (writers_d == '0)) begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              fill_d   = '0;
            end
          end
        end
        pbrb_pkg::OP_POLL: begin
          if (cmd_i.poll_rd) begin
            out_d.readable = ((fill_q != '0) || (writers_q == '0)) && cmd_i.events[0];
            out_d.hangup   = (writers_q == '0);
          end
          if (cmd_i.poll_wr) begin
            out_d.poll_error = (readers_q == '0);
            out_d.writable   = (readers_q != '0) && !ring_full && cmd_i.events[1];
          end
        end
        default: ;
      endcase
      used_ext         = UW'(fill_d);
      out_d.bytes_used = used_ext[pbrb_pkg::OUT_CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pbrb_pkg::B_IDLE;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      readers_q   <= '0;
      writers_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      fill_q      <= fill_d;
      readers_q   <= readers_d;
      writers_q   <= writers_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register, payload only
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // Ring memory, single port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_q[wr_ptr_q] <= cmd_i.data;
    end
    if (mem_re) begin
      rdata_q <= ring_q[rd_ptr_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== hdl/pipe_byte_ring_buffer.sv =====
// Byte ring buffer with reader and writer end counts.
// Input channel (in_valid_i/in_ready_o/in_i): one operation per beat -
// write_begin, write_byte, read_byte, open_end, close_end or poll.
// Output channel (out_valid_o/out_ready_i/out_o): exactly one result beat
// per operation, in order.
// A front end decodes each beat into a two-entry command queue; a back end
// executes commands against the ring memory and end counters and holds the
// result in an output register.
// A result passes through the command queue and the output register; a
// read_byte that pops a byte also passes through the registered read of the
// single-port ring memory. One operation per cycle while the receiver takes
// results; a popping read_byte also holds the back end in its read state.
// Reset clears pointers, fill count and end counts; ring contents are not
// cleared and are only ever read once written.
// When the receiver stalls the result is held, the back end stops at the
// next command and the queue fills; in_ready_o drops once two commands wait.
module pipe_byte_ring_buffer #(
  parameter int unsigned CAPACITY      = 4096,
  parameter int unsigned ATOMIC_LIMIT  = 512,
  parameter int unsigned END_COUNT_MAX = 255
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pbrb_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pbrb_pkg::out_t   out_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  pbrb_pkg::cmd_t cmd;

  pbrb_front #(
    .ATOMIC_LIMIT (ATOMIC_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pbrb_back #(
    .CAPACITY      (CAPACITY),
    .END_COUNT_MAX (END_COUNT_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
